// ===== rtl/core/rgsd_pkg.sv =====
// Shared constants, register indexes and controller/datapath types of the glyph span decoder.
`default_nettype none

package rgsd_pkg;

  localparam int MAX_GLYPH_WIDTH  = 64;
  localparam int MAX_GLYPH_HEIGHT = 64;
  localparam int SPAN_LIMIT       = 64;

  localparam int WORD_W      = 32;
  localparam int COORD_W     = 16;
  localparam int LEN_W       = 7;
  localparam int SIZE_W      = 7;
  localparam int REPEAT_W    = 16;
  localparam int LITLEFT_W   = 9;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int ALPHA_LSB   = 24;

  localparam logic [WORD_W-1:0]    LITERAL_MASK = 32'hFFFF_FF00;
  localparam logic [LITLEFT_W-1:0] LITERAL_BASE = 9'h100;

  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 4'd3;

  typedef struct packed {
    logic take_header;
    logic take_pixel;
    logic pixel_literal;
    logic emit_span;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic hdr_literal;
    logic lit_last;
    logic repeat_zero;
    logic overrun;
    logic out_free;
    logic span_final;
    logic span_glyph;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgsd_ifs.sv =====
// Channel interfaces of the glyph span decoder: word input, span output, register writes.
`default_nettype none

interface rgsd_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface rgsd_span_if;
  logic        valid;
  logic        ready;
  logic [15:0] span_x;
  logic [15:0] span_y;
  logic [6:0]  span_length;
  logic [31:0] color;
  logic        visible;
  logic        glyph_done;
  logic        last;
  modport source (output valid, output span_x, output span_y, output span_length,
                  output color, output visible, output glyph_done, output last,
                  input ready);
  modport sink   (input valid, input span_x, input span_y, input span_length,
                  input color, input visible, input glyph_done, input last,
                  output ready);
endinterface

interface rgsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rgsd_ctrl.sv =====
// Controller of the glyph span decoder: run phase and the span issue sequencer.
`default_nettype none

module rgsd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rgsd_pkg::status_t status,
  output rgsd_pkg::cmd_t        cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SPAN = 1'b1;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_VALUE   = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  logic       state;
  logic       state_next;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       lit;

  assign in_ready = (state == ST_IDLE);
  assign lit      = (phase == PH_LITERAL);

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (phase == PH_LITERAL || phase == PH_VALUE) begin
            cmd.take_pixel    = 1'b1;
            cmd.pixel_literal = lit;
            if (lit) begin
              phase_next = status.lit_last ? PH_HEADER : PH_LITERAL;
            end else begin
              phase_next = PH_HEADER;
            end
            // A repeat run of zero pixels swallows its value word silently.
            if (!lit && status.repeat_zero) begin
              state_next = ST_IDLE;
            end else if (status.overrun) begin
              cmd.clear  = 1'b1;
              phase_next = PH_HEADER;
            end else begin
              state_next = ST_SPAN;
            end
          end else begin
            cmd.take_header = 1'b1;
            phase_next      = status.hdr_literal ? PH_LITERAL : PH_VALUE;
          end
        end
      end
      ST_SPAN: begin
        if (status.out_free) begin
          cmd.emit_span = 1'b1;
          if (status.span_final) begin
            state_next = ST_IDLE;
          end
          if (status.span_glyph) begin
            cmd.clear  = 1'b1;
            phase_next = PH_HEADER;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_HEADER;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgsd_datapath.sv =====
// Datapath of the glyph span decoder: registers, run counters, span arithmetic, output register.
`default_nettype none

module rgsd_datapath #(
  parameter int MAX_GLYPH_WIDTH  = rgsd_pkg::MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = rgsd_pkg::MAX_GLYPH_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [rgsd_pkg::WORD_W-1:0]       data_word,
  input  wire logic                              cfg_fire,
  input  wire logic [rgsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rgsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire rgsd_pkg::cmd_t                    cmd,
  output rgsd_pkg::status_t                      status,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [rgsd_pkg::COORD_W-1:0]           span_x,
  output logic [rgsd_pkg::COORD_W-1:0]           span_y,
  output logic [rgsd_pkg::LEN_W-1:0]             span_length,
  output logic [rgsd_pkg::WORD_W-1:0]            color,
  output logic                                   visible,
  output logic                                   glyph_done,
  output logic                                   last
);

  localparam int EW_W  = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int EH_W  = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int TOT_W = $clog2(MAX_GLYPH_WIDTH * MAX_GLYPH_HEIGHT + 1);
  localparam int CNT_W = (TOT_W > rgsd_pkg::REPEAT_W) ? TOT_W : rgsd_pkg::REPEAT_W;
  localparam int N_W   = $clog2(rgsd_pkg::SPAN_LIMIT);
  localparam int PR_W  = EW_W + EH_W;

  function automatic logic [EW_W-1:0] sat_width(input logic [rgsd_pkg::SIZE_W-1:0] v);
    logic [EW_W-1:0] r;
    if (v == '0) begin
      r = EW_W'(1);
    end else if (32'(v) > 32'(MAX_GLYPH_WIDTH)) begin
      r = EW_W'(MAX_GLYPH_WIDTH);
    end else begin
      r = EW_W'(v);
    end
    return r;
  endfunction

  function automatic logic [EH_W-1:0] sat_height(input logic [rgsd_pkg::SIZE_W-1:0] v);
    logic [EH_W-1:0] r;
    if (v == '0) begin
      r = EH_W'(1);
    end else if (32'(v) > 32'(MAX_GLYPH_HEIGHT)) begin
      r = EH_W'(MAX_GLYPH_HEIGHT);
    end else begin
      r = EH_W'(v);
    end
    return r;
  endfunction

  // Configuration, kept already saturated, with the pixel total alongside.
  logic [EW_W-1:0]                  ew;
  logic [EW_W-1:0]                  ew_next;
  logic [EH_W-1:0]                  eh;
  logic [EH_W-1:0]                  eh_next;
  logic [TOT_W-1:0]                 total;
  logic [PR_W-1:0]                  total_prod;
  logic [rgsd_pkg::COORD_W-1:0]     origin_x;
  logic [rgsd_pkg::COORD_W-1:0]     origin_x_next;
  logic [rgsd_pkg::COORD_W-1:0]     origin_y;
  logic [rgsd_pkg::COORD_W-1:0]     origin_y_next;

  // Decoder state.
  logic [rgsd_pkg::LITLEFT_W-1:0]   literal_left;
  logic [rgsd_pkg::REPEAT_W-1:0]    repeat_count;
  logic [EW_W-1:0]                  column;
  logic [rgsd_pkg::COORD_W-1:0]     row;
  logic [TOT_W-1:0]                 pixels_done;
  logic [TOT_W-1:0]                 count_left;
  logic [N_W-1:0]                   span_cnt;
  logic [rgsd_pkg::WORD_W-1:0]      word;

  logic [TOT_W-1:0]                 remaining;
  logic [CNT_W-1:0]                 count_raw;
  logic [TOT_W-1:0]                 count_eff;
  logic                             wrap;
  logic [EW_W-1:0]                  col0;
  logic [rgsd_pkg::COORD_W-1:0]     row0;
  logic [EW_W-1:0]                  avail;
  logic [EW_W-1:0]                  len;
  logic [TOT_W-1:0]                 done_sum;
  logic                             glyph_end;
  logic                             span_final;

  always_comb begin
    ew_next       = ew;
    eh_next       = eh;
    origin_x_next = origin_x;
    origin_y_next = origin_y;
    if (cfg_fire) begin
      unique case (cfg_index)
        rgsd_pkg::REG_GLYPH_WIDTH:  ew_next = sat_width(cfg_data[rgsd_pkg::SIZE_W-1:0]);
        rgsd_pkg::REG_GLYPH_HEIGHT: eh_next = sat_height(cfg_data[rgsd_pkg::SIZE_W-1:0]);
        rgsd_pkg::REG_ORIGIN_X:     origin_x_next = cfg_data;
        rgsd_pkg::REG_ORIGIN_Y:     origin_y_next = cfg_data;
        default: ;
      endcase
    end
  end

  assign total_prod = PR_W'(ew_next) * PR_W'(eh_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      ew       <= EW_W'(1);
      eh       <= EH_W'(1);
      total    <= TOT_W'(1);
      origin_x <= '0;
      origin_y <= '0;
    end else begin
      ew       <= ew_next;
      eh       <= eh_next;
      total    <= TOT_W'(total_prod);
      origin_x <= origin_x_next;
      origin_y <= origin_y_next;
    end
  end

  // Per-word setup: the run is clipped to the pixels the glyph still lacks.
  assign remaining = total - pixels_done;
  assign count_raw = cmd.pixel_literal ? CNT_W'(1) : CNT_W'(repeat_count);
  assign count_eff = (count_raw > CNT_W'(remaining)) ? remaining : TOT_W'(count_raw);

  // Span step: wrap to the next row first, then cut at the row end.
  assign wrap      = (column >= ew);
  assign col0      = wrap ? '0 : column;
  assign row0      = wrap ? row + 1'b1 : row;
  assign avail     = ew - col0;
  assign len       = (TOT_W'(avail) > count_left) ? EW_W'(count_left) : avail;
  assign done_sum  = pixels_done + TOT_W'(len);
  assign glyph_end = (done_sum >= total);
  assign span_final = (count_left == TOT_W'(len)) || glyph_end ||
                      (span_cnt == N_W'(rgsd_pkg::SPAN_LIMIT - 1));

  assign status.hdr_literal = ((data_word & rgsd_pkg::LITERAL_MASK) == rgsd_pkg::LITERAL_MASK);
  assign status.lit_last    = (literal_left <= rgsd_pkg::LITLEFT_W'(1));
  assign status.repeat_zero = (repeat_count == '0);
  assign status.overrun     = (pixels_done >= total);
  assign status.out_free    = !out_valid || out_ready;
  assign status.span_final  = span_final;
  assign status.span_glyph  = glyph_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      literal_left <= '0;
      repeat_count <= '0;
      column       <= '0;
      row          <= '0;
      pixels_done  <= '0;
      count_left   <= '0;
      span_cnt     <= '0;
    end else if (cmd.clear) begin
      literal_left <= '0;
      repeat_count <= '0;
      column       <= '0;
      row          <= '0;
      pixels_done  <= '0;
    end else begin
      if (cmd.take_header) begin
        if (status.hdr_literal) begin
          literal_left <= rgsd_pkg::LITERAL_BASE - rgsd_pkg::LITLEFT_W'(data_word[7:0]);
        end else begin
          repeat_count <= data_word[rgsd_pkg::REPEAT_W-1:0];
        end
      end
      if (cmd.take_pixel) begin
        count_left <= count_eff;
        span_cnt   <= '0;
        if (cmd.pixel_literal && literal_left != '0) begin
          literal_left <= literal_left - 1'b1;
        end
      end
      if (cmd.emit_span) begin
        column      <= col0 + len;
        row         <= row0;
        pixels_done <= done_sum;
        count_left  <= count_left - TOT_W'(len);
        span_cnt    <= span_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      word <= data_word;
    end
  end

  // Output register: the next span is loaded as the current one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_span) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_span) begin
      span_x      <= origin_x + rgsd_pkg::COORD_W'(col0);
      span_y      <= origin_y + row0;
      span_length <= rgsd_pkg::LEN_W'(len);
      color       <= word;
      visible     <= (word[rgsd_pkg::WORD_W-1:rgsd_pkg::ALPHA_LSB] != '0);
      glyph_done  <= glyph_end;
      last        <= span_final;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rle_glyph_span_decoder.sv =====
// Top level of the glyph span decoder: controller, datapath and channel wiring.
//
//   channel  role    request carries
//   words    input   one compressed word: run header, repeat value or literal pixel
//   spans    output  one span: position, length, color, visible, glyph_done, last
//   cfg      input   register write: index 0..3 and data, always ready
//
// A header word is taken while idle. A pixel word is taken, then the span sequencer
// issues one span per cycle while the spans channel accepts; words is held off until
// the word's last span is in the output register. A stalled spans channel holds the
// sequencer. Synchronous reset returns the run state and registers to their initial
// values; there is no clearing pass.
`default_nettype none

module rle_glyph_span_decoder #(
  parameter int MAX_GLYPH_WIDTH  = rgsd_pkg::MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = rgsd_pkg::MAX_GLYPH_HEIGHT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  rgsd_word_if.sink     words,
  rgsd_span_if.source   spans,
  rgsd_cfg_if.sink      cfg
);

  rgsd_pkg::cmd_t    cmd;
  rgsd_pkg::status_t status;

  assign cfg.ready = 1'b1;

  rgsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (words.valid),
    .in_ready (words.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rgsd_datapath #(
    .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_word   (words.data_word),
    .cfg_fire    (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (spans.ready),
    .out_valid   (spans.valid),
    .span_x      (spans.span_x),
    .span_y      (spans.span_y),
    .span_length (spans.span_length),
    .color       (spans.color),
    .visible     (spans.visible),
    .glyph_done  (spans.glyph_done),
    .last        (spans.last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rgsd_checker.sv =====
// Port-level assertions of the glyph span decoder and their bind to the top level.
`default_nettype none

module rgsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        words_ready,
  input wire logic        spans_valid,
  input wire logic        spans_ready,
  input wire logic [15:0] span_x,
  input wire logic [15:0] span_y,
  input wire logic [6:0]  span_length,
  input wire logic [31:0] color,
  input wire logic        last
);

  // A stalled span keeps its contents.
  a_span_hold: assert property (@(posedge clk) disable iff (rst)
    spans_valid && !spans_ready |=>
      spans_valid && $stable(span_x) && $stable(span_y) && $stable(span_length) &&
      $stable(color) && $stable(last))
    else $error("span changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !spans_valid)
    else $error("span valid right after reset");

  // More spans of the same word are pending, so no new word may be taken.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    spans_valid && !last |-> !words_ready)
    else $error("word input ready while a run is still being issued");

  // The next span of a word follows in the cycle after the previous one leaves.
  a_span_follows: assert property (@(posedge clk) disable iff (rst)
    spans_valid && spans_ready && !last |=> spans_valid)
    else $error("gap in the spans of one word");

endmodule

bind rle_glyph_span_decoder rgsd_checker u_rgsd_checker (
  .clk         (clk),
  .rst         (rst),
  .words_ready (words.ready),
  .spans_valid (spans.valid),
  .spans_ready (spans.ready),
  .span_x      (spans.span_x),
  .span_y      (spans.span_y),
  .span_length (spans.span_length),
  .color       (spans.color),
  .last        (spans.last)
);

`default_nettype wire
